>>> hw/rtl/csv_sensor_line_parser_defines.svh
// ---------------------------------------------------------------------------
// csv_sensor_line_parser_defines: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CSV_SENSOR_LINE_PARSER_DEFINES_SVH
`define CSV_SENSOR_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CSL_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CSL_ASSERT(label, clk, rst, ante, cons, msg)
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/csl_pkg.sv
// ---------------------------------------------------------------------------
// csl_pkg: shared types and constants of the sensor line parser
// Character codes, token and result beats, widths of the parse state.
// ---------------------------------------------------------------------------
package csl_pkg;

   // line length limit and counter width
   localparam int LINE_MAX = 255;
   localparam int LEN_W    = $clog2(LINE_MAX + 1);

   // field storage
   localparam int WORD_W     = 32;
   localparam int NUM_FIELDS = 4;
   localparam int MIN_FIELDS = 3;
   localparam int IDX_W      = $clog2(NUM_FIELDS + 1);
   localparam int FIELD_AW   = $clog2(NUM_FIELDS);

   // digit accumulator saturates at 2^32
   localparam int ACC_W   = WORD_W + 1;
   localparam int ACC_X_W = ACC_W + 4;
   localparam logic [ACC_W-1:0]  ACC_CAP  = {1'b1, {WORD_W{1'b0}}};
   localparam logic [WORD_W-1:0] SINT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] SINT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // queue depths
   localparam int TOK_DEPTH = 4;
   localparam int TOK_AW    = $clog2(TOK_DEPTH);
   localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // byte classes handed from front to back
   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_COMMA,
      CLS_OTHER,
      CLS_END
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [3:0] digit;
   } token_type;

   typedef logic [NUM_FIELDS-1:0][WORD_W-1:0] readings_type;

   typedef struct packed {
      logic             accepted;
      logic [IDX_W-1:0] fields;
      readings_type     readings;
   } result_type;

   // number scanner phase
   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_SIGN   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

endpackage

>>> hw/rtl/csv_sensor_line_parser.sv
// ---------------------------------------------------------------------------
// csv_sensor_line_parser: byte-serial parser of comma separated sensor lines
// Throughput one byte a cycle while the result queue has room, set by the scanner taking one token a cycle.
// A line-end beat is registered in the token queue, then in the result queue, before its result shows.
// Synchronous reset empties both queues and zeroes the held readings.
// ---------------------------------------------------------------------------
`include "csv_sensor_line_parser_defines.svh"

module csv_sensor_line_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_line_accepted,
   output logic [2:0]         rsp_fields_parsed,
   output logic [31:0]        rsp_co2_ppm,
   output logic signed [31:0] rsp_temperature,
   output logic signed [31:0] rsp_humidity_tenths,
   output logic signed [31:0] rsp_light_level
);

   logic                fe_push;
   csl_pkg::token_type  fe_data;
   logic                tok_full;
   logic                tok_valid;
   logic                tok_pop;
   csl_pkg::token_type  tok_data;
   logic                be_push;
   csl_pkg::result_type be_data;
   logic                rq_full;
   logic                rq_valid;
   csl_pkg::result_type rq_data;

   // intake
   csl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .tok_full    (tok_full),
      .tok_push    (fe_push),
      .tok_data    (fe_data)
   );

   // decoupling queue
   csl_tok_queue u_tok_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_data),
      .full      (tok_full),
      .pop       (tok_pop),
      .valid     (tok_valid),
      .pop_data  (tok_data)
   );

   // scanner
   csl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok_data  (tok_data),
      .tok_pop   (tok_pop),
      .rsp_full  (rq_full),
      .rsp_push  (be_push),
      .rsp_data  (be_data)
   );

   // result queue
   csl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (be_push),
      .push_data (be_data),
      .full      (rq_full),
      .pop       (rsp_pop),
      .valid     (rq_valid),
      .pop_data  (rq_data)
   );

   // port mapping
   assign req_full            = tok_full;
   assign rsp_empty           = !rq_valid;
   assign rsp_line_accepted   = rq_data.accepted;
   assign rsp_fields_parsed   = rq_data.fields;
   assign rsp_co2_ppm         = rq_data.readings[0];
   assign rsp_temperature     = signed'(rq_data.readings[1]);
   assign rsp_humidity_tenths = signed'(rq_data.readings[2]);
   assign rsp_light_level     = signed'(rq_data.readings[3]);

   // checks
   `CSL_ASSERT(a_fields_range, clock, reset, !rsp_empty, rsp_fields_parsed <= 3'(csl_pkg::NUM_FIELDS), "field count above four")
   `CSL_ASSERT(a_accept_count, clock, reset, !rsp_empty && rsp_line_accepted, rsp_fields_parsed >= 3'(csl_pkg::MIN_FIELDS), "line accepted with too few fields")
   `CSL_ASSERT(a_light_zero, clock, reset, !rsp_empty && rsp_line_accepted && rsp_fields_parsed == 3'(csl_pkg::MIN_FIELDS), rsp_light_level == '0, "light not cleared on three-field line")
   `CSL_ASSERT_NEXT(a_end_result, clock, reset, tok_pop && tok_data.cls == csl_pkg::CLS_END, !rsp_empty, "line end without result")

endmodule

>>> hw/rtl/csl_front.sv
// ---------------------------------------------------------------------------
// csl_front: byte intake and classification
// Tracks line length, drops carriage returns and empty lines, and turns
// each byte into a class token or a line-end token.
// ---------------------------------------------------------------------------
module csl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_rx_byte,
   input  logic                 tok_full,
   output logic                 tok_push,
   output csl_pkg::token_type   tok_data
);

   logic [csl_pkg::LEN_W-1:0] len_ff;
   logic [csl_pkg::LEN_W-1:0] len_in;
   logic                      accept;

   // byte class lookup
   function automatic csl_pkg::cls_type classify(input logic [7:0] b);
      csl_pkg::cls_type c;
      if (b inside {[csl_pkg::CHAR_ZERO:csl_pkg::CHAR_NINE]}) begin
         c = csl_pkg::CLS_DIGIT;
      end else if (b inside {csl_pkg::CHAR_SPACE, csl_pkg::CHAR_TAB,
                             csl_pkg::CHAR_VT, csl_pkg::CHAR_FF}) begin
         c = csl_pkg::CLS_BLANK;
      end else if (b == csl_pkg::CHAR_PLUS) begin
         c = csl_pkg::CLS_PLUS;
      end else if (b == csl_pkg::CHAR_MINUS) begin
         c = csl_pkg::CLS_MINUS;
      end else if (b == csl_pkg::CHAR_COMMA) begin
         c = csl_pkg::CLS_COMMA;
      end else begin
         c = csl_pkg::CLS_OTHER;
      end
      return c;
   endfunction

   // line length and token issue
   always_comb begin
      accept         = req_push && !tok_full;
      len_in         = len_ff;
      tok_push       = 1'b0;
      tok_data.cls   = classify(req_rx_byte);
      tok_data.digit = req_rx_byte[3:0];
      if (accept && req_rx_byte != csl_pkg::CHAR_CR) begin
         if (req_rx_byte != csl_pkg::CHAR_LF &&
             len_ff < csl_pkg::LEN_W'(csl_pkg::LINE_MAX)) begin
            len_in   = len_ff + csl_pkg::LEN_W'(1);
            tok_push = 1'b1;
         end else if (len_ff != '0) begin
            // newline or overflow byte closes a non-empty line
            tok_data.cls = csl_pkg::CLS_END;
            tok_push     = 1'b1;
            len_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

>>> hw/rtl/csl_tok_queue.sv
// ---------------------------------------------------------------------------
// csl_tok_queue: token queue between front and back
// Four-entry register queue; lets the parser stall while bytes keep coming.
// ---------------------------------------------------------------------------
module csl_tok_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csl_pkg::token_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output csl_pkg::token_type pop_data
);

   csl_pkg::token_type            entry_ff [csl_pkg::TOK_DEPTH];
   csl_pkg::token_type            entry_in [csl_pkg::TOK_DEPTH];
   logic [csl_pkg::TOK_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::TOK_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::TOK_CNT_W-1:0] count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = count_ff == csl_pkg::TOK_CNT_W'(csl_pkg::TOK_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and count update
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = wr_ptr_ff + csl_pkg::TOK_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + csl_pkg::TOK_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + csl_pkg::TOK_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - csl_pkg::TOK_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> hw/rtl/csl_back.sv
// ---------------------------------------------------------------------------
// csl_back: field scanner and reading holder
// Runs the number scanner one token a cycle unless a line end waits on a full result
// queue, converts fields with saturation, and on line end issues a result beat.
// ---------------------------------------------------------------------------
module csl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  csl_pkg::token_type  tok_data,
   output logic                tok_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output csl_pkg::result_type rsp_data
);

   csl_pkg::phase_type               phase_ff, phase_in;
   logic                             stopped_ff, stopped_in;
   logic                             neg_ff, neg_in;
   logic [csl_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic [csl_pkg::IDX_W-1:0]        idx_ff, idx_in;
   csl_pkg::readings_type            fields_ff, fields_in;
   csl_pkg::readings_type            held_ff, held_in;

   logic                             is_end;
   logic                             is_digit;
   logic                             do_conv;
   logic [csl_pkg::WORD_W-1:0]       conv_val;
   csl_pkg::readings_type            fields_cv;
   logic [csl_pkg::IDX_W-1:0]        idx_cv;
   logic [csl_pkg::ACC_X_W-1:0]      acc_x;
   logic [csl_pkg::ACC_W-1:0]        acc_sat;
   logic                             accepted;

   // magnitude and sign to field value, saturating
   function automatic logic [csl_pkg::WORD_W-1:0] convert_field(
      input logic [csl_pkg::ACC_W-1:0] mag,
      input logic                      neg,
      input logic                      first
   );
      logic [csl_pkg::WORD_W-1:0] low;
      logic [csl_pkg::WORD_W-1:0] res;
      low = mag[csl_pkg::WORD_W-1:0];
      if (first) begin
         // unsigned field: minus wraps, overflow gives all ones
         if (mag[csl_pkg::ACC_W-1]) begin
            res = '1;
         end else begin
            res = neg ? (csl_pkg::WORD_W'(0) - low) : low;
         end
      end else if (neg) begin
         res = (mag > {1'b0, csl_pkg::SINT_MIN}) ? csl_pkg::SINT_MIN
                                                 : (csl_pkg::WORD_W'(0) - low);
      end else begin
         res = (mag > {1'b0, csl_pkg::SINT_MAX}) ? csl_pkg::SINT_MAX : low;
      end
      return res;
   endfunction

   assign is_end   = tok_data.cls == csl_pkg::CLS_END;
   assign is_digit = tok_data.cls == csl_pkg::CLS_DIGIT;
   assign tok_pop  = tok_valid && (!is_end || !rsp_full);

   // accumulate one decimal digit, capped at 2^32
   always_comb begin
      acc_x = (csl_pkg::ACC_X_W'(acc_ff) << 3) + (csl_pkg::ACC_X_W'(acc_ff) << 1)
            + csl_pkg::ACC_X_W'(tok_data.digit);
      if (acc_x > csl_pkg::ACC_X_W'(csl_pkg::ACC_CAP)) begin
         acc_sat = csl_pkg::ACC_CAP;
      end else begin
         acc_sat = acc_x[csl_pkg::ACC_W-1:0];
      end
   end

   // close the number in progress when a non-digit or line end arrives
   always_comb begin
      do_conv   = !stopped_ff && phase_ff == csl_pkg::PH_DIGITS && !is_digit;
      conv_val  = convert_field(acc_ff, neg_ff, idx_ff == '0);
      fields_cv = fields_ff;
      idx_cv    = idx_ff;
      if (do_conv) begin
         fields_cv[idx_ff[csl_pkg::FIELD_AW-1:0]] = conv_val;
         idx_cv = idx_ff + csl_pkg::IDX_W'(1);
      end
   end

   // scanner state and result issue
   always_comb begin
      phase_in   = phase_ff;
      stopped_in = stopped_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      fields_in  = fields_ff;
      held_in    = held_ff;
      rsp_push   = 1'b0;
      accepted   = idx_cv >= csl_pkg::IDX_W'(csl_pkg::MIN_FIELDS);
      rsp_data.accepted = accepted;
      rsp_data.fields   = idx_cv;
      rsp_data.readings = accepted ? fields_cv : held_ff;
      if (tok_pop) begin
         if (is_end) begin
            rsp_push = 1'b1;
            if (accepted) begin
               held_in = fields_cv;
            end
            phase_in   = csl_pkg::PH_SKIP;
            stopped_in = 1'b0;
            neg_in     = 1'b0;
            acc_in     = '0;
            idx_in     = '0;
            fields_in  = '0;
         end else if (!stopped_ff) begin
            case (phase_ff)
               csl_pkg::PH_SKIP: begin
                  if (tok_data.cls == csl_pkg::CLS_BLANK) begin
                     phase_in = csl_pkg::PH_SKIP;
                  end else if (tok_data.cls == csl_pkg::CLS_PLUS ||
                               tok_data.cls == csl_pkg::CLS_MINUS) begin
                     neg_in   = tok_data.cls == csl_pkg::CLS_MINUS;
                     phase_in = csl_pkg::PH_SIGN;
                  end else if (is_digit) begin
                     acc_in   = csl_pkg::ACC_W'(tok_data.digit);
                     phase_in = csl_pkg::PH_DIGITS;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
               csl_pkg::PH_SIGN: begin
                  if (is_digit) begin
                     acc_in   = csl_pkg::ACC_W'(tok_data.digit);
                     phase_in = csl_pkg::PH_DIGITS;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
               csl_pkg::PH_DIGITS: begin
                  if (is_digit) begin
                     acc_in = acc_sat;
                  end else begin
                     // field done; only a comma keeps the scan going, and only below four fields
                     fields_in  = fields_cv;
                     idx_in     = idx_cv;
                     phase_in   = csl_pkg::PH_SKIP;
                     neg_in     = 1'b0;
                     acc_in     = '0;
                     stopped_in = tok_data.cls != csl_pkg::CLS_COMMA ||
                                  idx_cv == csl_pkg::IDX_W'(csl_pkg::NUM_FIELDS);
                  end
               end
               default: begin
                  phase_in = csl_pkg::PH_SKIP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= csl_pkg::PH_SKIP;
         stopped_ff <= 1'b0;
         neg_ff     <= 1'b0;
         acc_ff     <= '0;
         idx_ff     <= '0;
         fields_ff  <= '0;
         held_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
         neg_ff     <= neg_in;
         acc_ff     <= acc_in;
         idx_ff     <= idx_in;
         fields_ff  <= fields_in;
         held_ff    <= held_in;
      end
   end

endmodule

>>> hw/rtl/csl_rsp_queue.sv
// ---------------------------------------------------------------------------
// csl_rsp_queue: result queue
// Two-entry register queue; the head entry drives the result ports.
// ---------------------------------------------------------------------------
module csl_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csl_pkg::result_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output csl_pkg::result_type pop_data
);

   csl_pkg::result_type           entry_ff [csl_pkg::RSP_DEPTH];
   csl_pkg::result_type           entry_in [csl_pkg::RSP_DEPTH];
   logic [csl_pkg::RSP_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [csl_pkg::RSP_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [csl_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = count_ff == csl_pkg::RSP_CNT_W'(csl_pkg::RSP_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and count update
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = wr_ptr_ff + csl_pkg::RSP_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + csl_pkg::RSP_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + csl_pkg::RSP_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - csl_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> verif/csv_sensor_line_parser_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csv_sensor_line_parser_check: line result predictor and comparator
// Watches the byte and result channels of the sensor line parser. Every
// accepted byte runs through a local copy of the line scanner. Each non-empty
// line end queues the summary the block should report. Each popped result beat is
// compared field by field against the oldest queued summary.
// ---------------------------------------------------------------------------
module csv_sensor_line_parser_check
   import csl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_line_accepted,
   input  logic [2:0]  rsp_fields_parsed,
   input  logic [31:0] rsp_co2_ppm,
   input  logic [31:0] rsp_temperature,
   input  logic [31:0] rsp_humidity_tenths,
   input  logic [31:0] rsp_light_level,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic        accepted;
      logic [2:0]  fields;
      logic [31:0] co2;
      logic [31:0] temp;
      logic [31:0] humid;
      logic [31:0] light;
   } line_summary_t;

   // scanner copy
   logic [LEN_W-1:0] line_len;
   logic [IDX_W-1:0] fld_idx;
   phase_type        phase;
   logic             stopped;
   logic             neg;
   logic [ACC_W-1:0] acc;
   logic [31:0]      line_val [NUM_FIELDS];
   logic [31:0]      held [NUM_FIELDS];

   line_summary_t summary_q [$];
   int            errors = 0;

   task automatic clear_line();
      line_len = '0;
      fld_idx  = '0;
      phase    = PH_SKIP;
      stopped  = 1'b0;
      neg      = 1'b0;
      acc      = '0;
      foreach (line_val[i]) line_val[i] = '0;
   endtask

   // turn the accumulated magnitude into a field value
   task automatic store_number();
      logic [31:0] v;
      if (fld_idx == 0) begin
         // unsigned field: overflow pins high, minus wraps
         if (acc > ACC_W'(32'hFFFF_FFFF))
            v = 32'hFFFF_FFFF;
         else if (neg)
            v = 32'd0 - acc[31:0];
         else
            v = acc[31:0];
      end else if (neg) begin
         v = (acc > ACC_W'(SINT_MIN)) ? SINT_MIN : 32'd0 - acc[31:0];
      end else begin
         v = (acc > ACC_W'(SINT_MAX)) ? SINT_MAX : acc[31:0];
      end
      line_val[fld_idx[FIELD_AW-1:0]] = v;
      fld_idx = fld_idx + 1'b1;
      phase   = PH_SKIP;
      neg     = 1'b0;
      acc     = '0;
      if (fld_idx >= NUM_FIELDS)
         stopped = 1'b1;
   endtask

   // one character of the line through the number scanner
   task automatic scan_char(input logic [7:0] c);
      logic [ACC_X_W-1:0] grown;
      logic               is_digit;
      logic               is_blank;
      if (stopped)
         return;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
      case (phase)
         PH_SKIP: begin
            if (is_blank) begin
               // leading whitespace stays in this phase
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               neg   = (c == CHAR_MINUS);
               phase = PH_SIGN;
            end else if (is_digit) begin
               acc   = ACC_W'(c - CHAR_ZERO);
               phase = PH_DIGITS;
            end else begin
               stopped = 1'b1;
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               acc   = ACC_W'(c - CHAR_ZERO);
               phase = PH_DIGITS;
            end else begin
               stopped = 1'b1;
            end
         end
         default: begin
            if (is_digit) begin
               grown = ACC_X_W'(acc) * 10 + ACC_X_W'(c - CHAR_ZERO);
               acc   = (grown > ACC_X_W'(ACC_CAP)) ? ACC_CAP : grown[ACC_W-1:0];
            end else begin
               store_number();
               if (!stopped && c != CHAR_COMMA)
                  stopped = 1'b1;
            end
         end
      endcase
   endtask

   // one accepted byte: extend the line or close it
   task automatic take_byte(input logic [7:0] c);
      line_summary_t s;
      if (c == CHAR_CR)
         return;
      if (c != CHAR_LF && line_len < LINE_MAX) begin
         line_len = line_len + 1'b1;
         scan_char(c);
         return;
      end
      // empty line gives no beat
      if (line_len == 0) begin
         clear_line();
         return;
      end
      if (!stopped && phase == PH_DIGITS)
         store_number();
      if (fld_idx >= MIN_FIELDS)
         held = line_val;
      s.accepted = (fld_idx >= MIN_FIELDS);
      s.fields   = fld_idx;
      s.co2      = held[0];
      s.temp     = held[1];
      s.humid    = held[2];
      s.light    = held[3];
      summary_q.push_back(s);
      clear_line();
   endtask

   function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // compare result beats, then predict from byte beats
   always @(posedge clock) begin
      line_summary_t want;
      int            bad;
      if (reset) begin
         clear_line();
         foreach (held[i]) held[i] = '0;
         summary_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (summary_q.size() == 0) begin
               $error("result beat with no line end waiting");
               errors++;
            end else begin
               want = summary_q.pop_front();
               bad  = 0;
               bad += field_differs("line_accepted", 32'(want.accepted),
                                    32'(rsp_line_accepted));
               bad += field_differs("fields_parsed", 32'(want.fields),
                                    32'(rsp_fields_parsed));
               bad += field_differs("co2_ppm", want.co2, rsp_co2_ppm);
               bad += field_differs("temperature", want.temp, rsp_temperature);
               bad += field_differs("humidity_tenths", want.humid, rsp_humidity_tenths);
               bad += field_differs("light_level", want.light, rsp_light_level);
               if (bad != 0)
                  errors++;
            end
         end
         if (req_push && !req_full)
            take_byte(req_rx_byte);
      end
      pending    <= summary_q.size();
      fail_count <= errors;
   end

endmodule

>>> verif/csv_sensor_line_parser_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csv_sensor_line_parser_test: top of the sensor line parser testbench
// Feeds directed lines covering number extremes, overflow, whitespace, signs,
// bad separators, NUL, empty and full lines, then random well-formed, broken
// and noise lines with random idle on both channels. Checking is done by the
// line checker beside the block; this top gives the verdict.
// ---------------------------------------------------------------------------
module csv_sensor_line_parser_test;
   import csl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 1050;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_line_accepted;
   logic [2:0]  rsp_fields_parsed;
   logic [31:0] rsp_co2_ppm;
   logic signed [31:0] rsp_temperature;
   logic signed [31:0] rsp_humidity_tenths;
   logic signed [31:0] rsp_light_level;

   logic        calm = 1'b0;
   int          pop_hold = 0;
   int          cycles = 0;
   int          fail_count;
   int          pending;
   int          sent;
   logic [7:0]  line_bytes [$];

   csv_sensor_line_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_line_accepted   (rsp_line_accepted),
      .rsp_fields_parsed   (rsp_fields_parsed),
      .rsp_co2_ppm         (rsp_co2_ppm),
      .rsp_temperature     (rsp_temperature),
      .rsp_humidity_tenths (rsp_humidity_tenths),
      .rsp_light_level     (rsp_light_level)
   );

   csv_sensor_line_parser_check line_check (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_line_accepted   (rsp_line_accepted),
      .rsp_fields_parsed   (rsp_fields_parsed),
      .rsp_co2_ppm         (rsp_co2_ppm),
      .rsp_temperature     (rsp_temperature),
      .rsp_humidity_tenths (rsp_humidity_tenths),
      .rsp_light_level     (rsp_light_level),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always #1 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("csv_sensor_line_parser_test: FAIL");
         $finish;
      end
   end

   // result side: random pops with occasional long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (calm) begin
         rsp_pop <= 1'b1;
      end else begin
         if ($urandom_range(199) == 0)
            pop_hold <= $urandom_range(60, 20);
         rsp_pop <= ($urandom_range(99) >= 35);
      end
   end

   // one byte beat, with random idle ahead of it
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 35) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // random number field: optional blanks and sign, digits of mixed length
   task automatic add_number();
      int    len;
      int    r;
      string lit;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(3))
               0:       line_bytes.push_back(CHAR_SPACE);
               1:       line_bytes.push_back(CHAR_TAB);
               2:       line_bytes.push_back(CHAR_VT);
               default: line_bytes.push_back(CHAR_FF);
            endcase
         end
      end
      if ($urandom_range(99) < 20)
         line_bytes.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      r = $urandom_range(99);
      if (r < 6) begin
         // values at the edges of the field ranges
         case ($urandom_range(5))
            0:       lit = "4294967295";
            1:       lit = "4294967296";
            2:       lit = "2147483647";
            3:       lit = "2147483648";
            4:       lit = "2147483649";
            default: lit = "0";
         endcase
         for (int i = 0; i < lit.len(); i++)
            line_bytes.push_back(lit[i]);
      end else begin
         if (r < 60)
            len = $urandom_range(4, 1);
         else if (r < 85)
            len = $urandom_range(9, 5);
         else if (r < 95)
            len = 10;
         else
            len = $urandom_range(22, 11);
         repeat (len)
            line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
      end
   endtask

   // random line: mostly well formed, some broken, noise, empty or overlong
   task automatic build_line();
      int    kind;
      int    r;
      int    nf;
      string pool;
      pool = "0123456789,,, -+";
      line_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 85) begin
         r = $urandom_range(99);
         if (r < 40)      nf = 3;
         else if (r < 80) nf = 4;
         else if (r < 88) nf = 5;
         else if (r < 94) nf = 2;
         else             nf = 1;
         for (int f = 0; f < nf; f++) begin
            if (f != 0)
               line_bytes.push_back(CHAR_COMMA);
            add_number();
         end
         if (kind >= 82)
            line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'h00;
         else if (kind >= 70)
            line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom);
      end else if (kind < 95) begin
         repeat ($urandom_range(20, 1))
            line_bytes.push_back(8'($urandom));
      end else if (kind < 99) begin
         if ($urandom_range(1))
            line_bytes.push_back(CHAR_CR);
      end else begin
         repeat ($urandom_range(300, 250))
            line_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
      end
      line_bytes.push_back(CHAR_LF);
   endtask

   task automatic run_directed();
      send_text("400,215,455,1200\n");
      // empty line
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_text("4294967295,2147483647,-2147483648,-2147483648\n");
      send_text("4294967296,2147483648,-2147483649,99999999999999999999999\n");
      // minus on the unsigned field wraps
      send_text("-1,-0,+7,+0\n");
      // every blank before a number, carriage returns inside the line
      send_byte(CHAR_SPACE);
      send_byte(CHAR_TAB);
      send_byte(CHAR_VT);
      send_byte(CHAR_FF);
      send_text("12,+3,");
      send_byte(CHAR_CR);
      send_text("\t-4");
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_text("1,2,3\n");
      send_text("1,2,3,4,5\n");
      send_text("1,2\n");
      send_text("   \n");
      send_text("abc");
      send_byte(8'hFF);
      send_byte(CHAR_LF);
      send_text("1,+,3,4\n");
      send_text("1,2,3,-\n");
      send_text("1;2,3,4\n");
      // NUL stops the scan but keeps the number in progress
      send_text("5,6,7");
      send_byte(8'h00);
      send_text(",8\n");
      send_text("9,8,7,6 trailing\n");
      send_text("1, 2 ,3\n");
      // full line: the next byte is dropped and closes it
      send_text("11,22,33,");
      repeat (LINE_MAX - 9) send_byte(8'h34);
      send_byte(CHAR_NINE);
      // full line closed by newline, carriage return ignored at full
      send_text("1,2,3,");
      repeat (LINE_MAX - 6) send_byte(8'h37);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_text("7,7,7\n");
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();

      // random lines, with a calm stretch in the middle
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         calm <= (sent >= 400 && sent < 750);
         build_line();
         foreach (line_bytes[i]) begin
            send_byte(line_bytes[i]);
            if ($urandom_range(99) < 3)
               send_byte(CHAR_CR);
         end
         sent += line_bytes.size();
      end
      req_push <= 1'b0;
      calm     <= 1'b1;

      // drain outstanding results
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("csv_sensor_line_parser_test: PASS");
      else
         $display("csv_sensor_line_parser_test: FAIL");
      $finish;
   end

endmodule

>>> csv_sensor_line_parser.f
+incdir+hw/rtl
hw/rtl/csl_pkg.sv
hw/rtl/csl_front.sv
hw/rtl/csl_tok_queue.sv
hw/rtl/csl_back.sv
hw/rtl/csl_rsp_queue.sv
hw/rtl/csv_sensor_line_parser.sv
verif/csv_sensor_line_parser_check.sv
verif/csv_sensor_line_parser_test.sv
